// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising edge out of reset.
`define KSL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define KSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

// File: rtl/ksl_pkg.sv
// ---------------------------------------------------------------------------
// Keyed sequential list package
// Command and status codes, field widths and the default table depth.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int RESULT_W = 24;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

// File: rtl/ksl_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read, no reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksl_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/keyed_sequential_list.sv
// ---------------------------------------------------------------------------
// Keyed sequential list
// Packed insertion-ordered key table with append, search and remove.
// ---------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH 32-bit keys in one RAM in insertion
// order and takes one command word at a time on the slave stream (command
// in s_tuser, key in s_tdata). Every command gives exactly one result word on
// the master stream. An append is resolved in the accept cycle, and its
// result then passes through the done state into the output register. A
// search reads the stored entries through the single RAM read port, one
// entry per cycle with the compare in the cycle after the read. A remove
// does the same search up to the hit and then moves each later entry down
// one place, again one entry per cycle through the same read port. The
// next command is accepted once the current result has been handed to the
// output register, which holds it until the sink takes it. No clearing pass
// is needed after reset: only entries below the count are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keyed_sequential_list #(
    parameter int TABLE_DEPTH = ksl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: key[31:0].
    input  logic [ksl_pkg::KEY_W-1:0]     s_tdata,
    // Fields from bit 0 up: cmd[1:0].
    input  logic [ksl_pkg::CMD_W-1:0]     s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: status[1:0], position[7:2], entry_count[14:8],
    // is_full[15], is_empty[16], zero fill[23:17].
    output logic [ksl_pkg::RESULT_W-1:0]  m_tdata
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam int PAD_W = ksl_pkg::RESULT_W - ksl_pkg::STATUS_W - ksl_pkg::POS_W
                           - ksl_pkg::COUNT_W - 2;

    // Control state.
    ksl_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;     // next entry to read
    logic             pend_reg, pend_next;         // a read is in flight
    logic             m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [ADDR_W-1:0]               pend_idx_reg, pend_idx_next;
    logic [ksl_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [ksl_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [ksl_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [ADDR_W-1:0]               pos_reg, pos_next;
    logic [ksl_pkg::RESULT_W-1:0]    m_tdata_reg, m_tdata_next;

    // RAM ports.
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ksl_pkg::KEY_W-1:0] wr_data;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ksl_pkg::KEY_W-1:0] rd_data;

    logic s_accept;
    logic out_free;
    logic can_issue;
    logic hit;

    ksl_ram #(
        .DATA_W (ksl_pkg::KEY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ksl_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A read is issued only for entries that hold a key, so a never-written
    // location is never read.
    assign can_issue = (rd_idx_reg < count_reg);
    assign hit       = pend_reg && (rd_data == key_reg);
    assign rd_addr   = rd_idx_reg[ADDR_W-1:0];

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = s_tdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ksl_pkg::S_IDLE: begin
                if (s_accept) begin
                    cmd_next    = s_tuser;
                    key_next    = s_tdata;
                    status_next = ksl_pkg::ST_OK;
                    pos_next    = '0;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ksl_pkg::S_DONE;
                    case (s_tuser)
                        ksl_pkg::CMD_APPEND: begin
                            if (count_reg >= DEPTH_CNT) begin
                                status_next = ksl_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                pos_next   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ksl_pkg::CMD_SEARCH, ksl_pkg::CMD_REMOVE: begin
                            state_next = ksl_pkg::S_SCAN;
                        end
                        default: begin
                            // Unused command code: no operation.
                        end
                    endcase
                end
            end

            ksl_pkg::S_SCAN: begin
                if (hit) begin
                    pos_next  = pend_idx_reg;
                    pend_next = 1'b0;
                    if (cmd_reg == ksl_pkg::CMD_REMOVE) begin
                        rd_idx_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                        state_next  = ksl_pkg::S_SHIFT;
                    end else begin
                        state_next = ksl_pkg::S_DONE;
                    end
                end else if (!pend_reg && !can_issue) begin
                    status_next = ksl_pkg::ST_NOT_FOUND;
                    state_next  = ksl_pkg::S_DONE;
                end else begin
                    pend_next     = can_issue;
                    pend_idx_next = rd_idx_reg[ADDR_W-1:0];
                    if (can_issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            ksl_pkg::S_SHIFT: begin
                // The entry read last cycle moves down one place while the
                // next one is read; the write always trails the read address.
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg - ADDR_W'(1);
                    wr_data = rd_data;
                end
                if (!pend_reg && !can_issue) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ksl_pkg::S_DONE;
                end else begin
                    pend_next     = can_issue;
                    pend_idx_next = rd_idx_reg[ADDR_W-1:0];
                    if (can_issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            ksl_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        {PAD_W{1'b0}},
                        (count_reg == '0),
                        (count_reg == DEPTH_CNT),
                        ksl_pkg::COUNT_W'(count_reg),
                        ksl_pkg::POS_W'(pos_reg),
                        status_reg
                    };
                    state_next = ksl_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ksl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ksl_pkg::S_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // The count never exceeds the table depth.
    `KSL_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_CNT)
    // A read is in flight only while scanning or shifting.
    `KSL_ASSERT_ALWAYS(a_pend_state,
                       !pend_reg || state_reg == ksl_pkg::S_SCAN || state_reg == ksl_pkg::S_SHIFT)
    // An accepted command keeps the input closed on the next cycle.
    `KSL_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready)

endmodule

// File: test/keyed_sequential_list_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyed sequential list testbench
// Drives append, search, remove and unused command words into the list and
// checks every result word against a shadow copy of the key table kept here.
// ---------------------------------------------------------------------------
// A short directed part covers the empty table, the extreme keys, duplicate
// keys and every command. Then fill and drain rounds take the table to full
// and back to empty. A long random mix follows, in phases that alternately
// grow and shrink the table. Both the command side and the result side
// insert random gaps, with some phases that have none.
// ---------------------------------------------------------------------------

module keyed_sequential_list_tb;

    import ksl_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    // Command code that the block treats as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Settle time after the last result, longer than the slowest remove.
    localparam int DRAIN_CYCLES = DEPTH + 16;

    // Result word layout, from the top bit down.
    typedef struct packed {
        logic [6:0]          pad;
        logic                is_empty;
        logic                is_full;
        logic [COUNT_W-1:0]  entry_count;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } list_reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [KEY_W-1:0]    s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;

    // Shadow of the stored keys in table order; its size is the entry count.
    logic [KEY_W-1:0] shadow_keys[$];
    // Results predicted for accepted commands, oldest first.
    list_reply_t      table_replies[$];

    int mismatches   = 0;
    int src_gap_max  = 3;
    int sink_gap_max = 3;
    int hang_count   = 0;

    keyed_sequential_list uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Applies one command to the shadow table and returns the result word
    // the block should give for it.
    function automatic list_reply_t predict_table_op(input logic [CMD_W-1:0] op,
                                                     input logic [KEY_W-1:0] k);
        list_reply_t r;
        int          hit;
        int          i;
        r      = '0;
        r.status = ST_OK;
        hit    = -1;
        if (op == CMD_APPEND) begin
            if (shadow_keys.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                r.position = POS_W'(shadow_keys.size());
                shadow_keys.push_back(k);
            end
        end else if (op == CMD_SEARCH || op == CMD_REMOVE) begin
            // The first matching entry wins when a key is stored twice.
            for (i = 0; i < shadow_keys.size(); i++) begin
                if (hit < 0 && shadow_keys[i] == k) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.position = POS_W'(hit);
                if (op == CMD_REMOVE) begin
                    shadow_keys.delete(hit);
                end
            end
        end
        r.entry_count = COUNT_W'(shadow_keys.size());
        r.is_full     = (shadow_keys.size() == DEPTH);
        r.is_empty    = (shadow_keys.size() == 0);
        return r;
    endfunction

    // Mostly keys already stored, some from a tiny pool so that duplicates
    // and misses are common, the rest fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (shadow_keys.size() != 0 && r < 6) begin
            return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
        end else if (r < 8) begin
            return KEY_W'($urandom_range(0, 7));
        end
        return $urandom;
    endfunction

    // Sends one command word after a random gap. Valid stays high when the
    // next word follows without a gap, so it is never lowered and raised in
    // the same step.
    task automatic issue_command(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        table_replies.push_back(predict_table_op(op, k));
    endtask

    task automatic pick_gaps();
        src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
        sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    endtask

    // Empty table, then the extreme keys and a duplicate.
    task automatic test_empty_table();
        issue_command(CMD_SEARCH, 32'h0000_0000);
        issue_command(CMD_REMOVE, 32'h8000_0000);
        issue_command(CMD_UNUSED, 32'hFFFF_FFFF);
        issue_command(CMD_APPEND, 32'h8000_0000);
        issue_command(CMD_APPEND, 32'h7FFF_FFFF);
        issue_command(CMD_APPEND, 32'h0000_0000);
        issue_command(CMD_APPEND, 32'hFFFF_FFFF);
        issue_command(CMD_APPEND, 32'h7FFF_FFFF);
    endtask

    // Hits at the ends and in the middle, first match among duplicates,
    // misses, the unused code, and removes down to an empty table.
    task automatic test_basic_ops();
        issue_command(CMD_SEARCH, 32'h8000_0000);
        issue_command(CMD_SEARCH, 32'h7FFF_FFFF);
        issue_command(CMD_SEARCH, 32'hFFFF_FFFF);
        issue_command(CMD_SEARCH, 32'h1234_5678);
        issue_command(CMD_UNUSED, 32'h7FFF_FFFF);
        issue_command(CMD_REMOVE, 32'h7FFF_FFFF);
        issue_command(CMD_SEARCH, 32'h7FFF_FFFF);
        issue_command(CMD_REMOVE, 32'hFFFF_FFFF);
        issue_command(CMD_REMOVE, 32'h7FFF_FFFF);
        issue_command(CMD_REMOVE, 32'h8000_0000);
        issue_command(CMD_REMOVE, 32'h1234_5678);
        issue_command(CMD_REMOVE, 32'h0000_0000);
        issue_command(CMD_SEARCH, 32'h0000_0000);
    endtask

    // Fills the table to full, appends past the end, searches, then drains
    // it by removing stored keys in random order.
    task automatic test_fill_and_drain(input int rounds);
        int rnd;
        int n;
        for (rnd = 0; rnd < rounds; rnd++) begin
            pick_gaps();
            while (shadow_keys.size() < DEPTH) begin
                issue_command(CMD_APPEND, pick_key());
            end
            issue_command(CMD_APPEND, $urandom);
            issue_command(CMD_APPEND, pick_key());
            for (n = 0; n < 5; n++) begin
                issue_command(CMD_SEARCH, pick_key());
            end
            // The first entry forces the longest shift.
            issue_command(CMD_REMOVE, shadow_keys[0]);
            n = 0;
            while (shadow_keys.size() != 0) begin
                issue_command(CMD_REMOVE,
                              shadow_keys[$urandom_range(0, shadow_keys.size() - 1)]);
                n++;
                if (n % 8 == 0) begin
                    issue_command(CMD_SEARCH, pick_key());
                end
            end
        end
    endtask

    // Random commands in phases that alternately grow and shrink the table.
    task automatic test_random_mix(input int count);
        int          j;
        int          r;
        logic        grow;
        logic [CMD_W-1:0] op;
        grow = 1'b0;
        for (j = 0; j < count; j++) begin
            if (j % 150 == 0) begin
                grow = ~grow;
                pick_gaps();
            end
            r = $urandom_range(0, 99);
            if (grow) begin
                op = (r < 55) ? CMD_APPEND : (r < 80) ? CMD_SEARCH :
                     (r < 97) ? CMD_REMOVE : CMD_UNUSED;
            end else begin
                op = (r < 20) ? CMD_APPEND : (r < 50) ? CMD_SEARCH :
                     (r < 97) ? CMD_REMOVE : CMD_UNUSED;
            end
            issue_command(op, pick_key());
        end
    endtask

    // Result side: after each accepted word the sink may hold ready low for
    // a random number of cycles.
    always @(posedge aclk) begin : result_sink
        int gap;
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold = 0;
        end else if (hold != 0) begin
            hold = hold - 1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid) begin
            gap = $urandom_range(0, sink_gap_max);
            if (gap != 0) begin
                m_tready <= 1'b0;
                hold = gap - 1;
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : reply_check
        list_reply_t got;
        list_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (table_replies.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = table_replies.pop_front();
                compare_field("status",      want.status,      got.status);
                compare_field("position",    want.position,    got.position);
                compare_field("entry_count", want.entry_count, got.entry_count);
                compare_field("is_full",     want.is_full,     got.is_full);
                compare_field("is_empty",    want.is_empty,    got.is_empty);
                compare_field("fill bits",   want.pad,         got.pad);
            end
        end
    end

    // Ends a hung run: no word moved on either side for too long.
    always @(posedge aclk) begin : hang_watch
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            hang_count <= 0;
        end else begin
            hang_count <= hang_count + 1;
            if (hang_count >= HANG_LIMIT) begin
                $display("keyed_sequential_list_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_basic_ops();
        test_fill_and_drain(3);
        test_random_mix(1500);
        s_tvalid <= 1'b0;
        while (table_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("keyed_sequential_list_tb: done, clean");
        end else begin
            $display("keyed_sequential_list_tb: done, errors");
        end
        $finish;
    end

endmodule
